[rtl/core/ffr_pkg.sv]
// ----------------------------------------------------------------------------
// ffr_pkg: shared types and helpers for the Fletcher frame receiver
// Holds the parse phases, verdict codes, register indexes, reset values and
// the modulo-255 adder used by the checksum.
// ----------------------------------------------------------------------------
package ffr_pkg;

	// Configuration register indexes and reset values.
	localparam int unsigned CfgIndexW = 2;
	localparam logic [CfgIndexW-1:0] CFG_HEADER_FIRST  = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_HEADER_SECOND = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_MAX_PAYLOAD   = 2'd2;

	localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
	localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
	localparam logic [3:0] MAX_PAYLOAD_RST   = 4'd15;

	// Result kinds.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Frame verdicts.
	typedef enum logic [1:0] {
		VERDICT_OK         = 2'd0,
		VERDICT_BAD_HEADER = 2'd1,
		VERDICT_TOO_LONG   = 2'd2,
		VERDICT_BAD_CHECK  = 2'd3
	} verdict_t;

	// Parse phases of the receive state machine.
	typedef enum logic [2:0] {
		PH_HEAD1     = 3'd0,
		PH_HEAD2_OK  = 3'd1,
		PH_HEAD2_BAD = 3'd2,
		PH_ID        = 3'd3,
		PH_PAYLOAD   = 3'd4,
		PH_CHECK_HI  = 3'd5,
		PH_CHECK_LO  = 3'd6
	} phase_t;

	// Configuration as seen by the parser.
	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [3:0] max_payload;
	} ffr_cfg_t;

	// One result item.
	typedef struct packed {
		logic       out_kind;
		logic [7:0] payload_byte;
		logic [3:0] byte_position;
		logic [3:0] command;
		logic [3:0] frame_length;
		verdict_t   verdict;
	} ffr_result_t;

	// Sum of two bytes modulo 255. Either operand may be 255, so the sum can
	// reach 510, which reduces to zero.
	function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] sum;
		logic [8:0] red;
		sum = {1'b0, a} + {1'b0, b};
		red = (sum >= 9'd255) ? sum - 9'd255 : sum;
		if (red == 9'd255) begin
			red = 9'd0;
		end
		return red[7:0];
	endfunction

endpackage

[rtl/core/ffr_parser.sv]
// ----------------------------------------------------------------------------
// ffr_parser: frame state machine and Fletcher-16 check
// Consumes one byte per step, tracks the frame phase and the two running
// sums, and produces at most one result per byte.
// ----------------------------------------------------------------------------
module ffr_parser
	import ffr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  byte_in,
	input  ffr_cfg_t    cfg,
	output logic        res_valid,
	output ffr_result_t res
);

	phase_t     phase_q, phase_d;
	logic [3:0] cmd_q;
	logic [3:0] len_q;
	logic [3:0] seen_q;
	logic [7:0] sum1_q;
	logic [7:0] sum2_q;
	logic [7:0] check_hi_q;

	logic [7:0] sum1_next;
	logic [7:0] sum2_next;
	logic [3:0] seen_next;
	logic       check_good;

	// Checksum and position arithmetic for the current byte.
	always_comb begin
		sum1_next  = add_mod255(sum1_q, byte_in);
		sum2_next  = add_mod255(sum2_q, sum1_next);
		seen_next  = seen_q + 4'd1;
		check_good = (check_hi_q == sum1_q) && (byte_in == sum2_q);
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HEAD1: begin
				phase_d = (byte_in == cfg.header_first) ? PH_HEAD2_OK : PH_HEAD2_BAD;
			end
			PH_HEAD2_OK: begin
				phase_d = (byte_in == cfg.header_second) ? PH_ID : PH_HEAD1;
			end
			PH_HEAD2_BAD: begin
				phase_d = PH_HEAD1;
			end
			PH_ID: begin
				if (byte_in[3:0] > cfg.max_payload) begin
					phase_d = PH_HEAD1;
				end else if (byte_in[3:0] == 4'd0) begin
					phase_d = PH_CHECK_HI;
				end else begin
					phase_d = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				phase_d = (seen_next >= len_q) ? PH_CHECK_HI : PH_PAYLOAD;
			end
			PH_CHECK_HI: begin
				phase_d = PH_CHECK_LO;
			end
			PH_CHECK_LO: begin
				phase_d = PH_HEAD1;
			end
			default: begin
				phase_d = PH_HEAD1;
			end
		endcase
	end

	// Result produced by the current byte.
	always_comb begin
		res_valid = 1'b0;
		res       = '{out_kind: KIND_VERDICT, payload_byte: 8'd0, byte_position: 4'd0,
		              command: 4'd0, frame_length: 4'd0, verdict: VERDICT_OK};
		case (phase_q)
			PH_HEAD2_OK: begin
				if (byte_in != cfg.header_second) begin
					res_valid   = 1'b1;
					res.verdict = VERDICT_BAD_HEADER;
				end
			end
			PH_HEAD2_BAD: begin
				res_valid   = 1'b1;
				res.verdict = VERDICT_BAD_HEADER;
			end
			PH_ID: begin
				if (byte_in[3:0] > cfg.max_payload) begin
					res_valid        = 1'b1;
					res.command      = byte_in[7:4];
					res.frame_length = byte_in[3:0];
					res.verdict      = VERDICT_TOO_LONG;
				end
			end
			PH_PAYLOAD: begin
				res_valid         = 1'b1;
				res.out_kind      = KIND_PAYLOAD;
				res.payload_byte  = byte_in;
				res.byte_position = seen_q;
				res.command       = cmd_q;
				res.frame_length  = len_q;
			end
			PH_CHECK_LO: begin
				res_valid        = 1'b1;
				res.command      = cmd_q;
				res.frame_length = len_q;
				res.verdict      = check_good ? VERDICT_OK : VERDICT_BAD_CHECK;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Phase and frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEAD1;
			cmd_q      <= 4'd0;
			len_q      <= 4'd0;
			seen_q     <= 4'd0;
			sum1_q     <= 8'd0;
			sum2_q     <= 8'd0;
			check_hi_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			case (phase_q)
				PH_ID: begin
					cmd_q  <= byte_in[7:4];
					len_q  <= byte_in[3:0];
					seen_q <= 4'd0;
					sum1_q <= byte_in;
					sum2_q <= byte_in;
				end
				PH_PAYLOAD: begin
					seen_q <= seen_next;
					sum1_q <= sum1_next;
					sum2_q <= sum2_next;
				end
				PH_CHECK_HI: begin
					check_hi_q <= byte_in;
				end
				default: begin
					check_hi_q <= check_hi_q;
				end
			endcase
		end
	end

endmodule

[rtl/core/fletcher_frame_receiver.sv]
// ----------------------------------------------------------------------------
// fletcher_frame_receiver: deframer with Fletcher-16 frame check
// Recognizes header, ID, payload and check bytes in a received byte stream,
// passes payload bytes on and ends each frame with a verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes enter on rx_valid/rx_ready/rx_byte, one request per byte. Results
//   leave on out_valid/out_ready with one port per field: a payload byte
//   (out_kind 0) for each payload byte, and a verdict (out_kind 1) after the
//   second header byte on a header mismatch, after the ID byte on a too-long
//   length, or after the check low byte.
//   A byte is held in an input register, parsed when the output register is
//   free or draining, and its result is then shown from the output register.
//   One byte is taken every cycle while results drain, because each register
//   reloads in the same cycle that it empties.
//   When out_ready is low with a result waiting, parsing stops, the input
//   register fills, and rx_ready drops until the result is taken.
//   Reset clears both registers' valid flags, returns the parser to waiting
//   for a first header byte and loads the register defaults (170, 85, 15).
//   Configuration writes via cfg_we/cfg_index/cfg_data take effect at once
//   and are meant for idle periods only.
// ----------------------------------------------------------------------------
module fletcher_frame_receiver
	import ffr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 rx_valid,
	output logic                 rx_ready,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 out_kind,
	output logic [7:0]           payload_byte,
	output logic [3:0]           byte_position,
	output logic [3:0]           command,
	output logic [3:0]           frame_length,
	output logic [1:0]           verdict
);

	ffr_cfg_t    cfg_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	ffr_result_t res_s2;
	logic        advance;
	logic        res_valid;
	ffr_result_t res;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HEADER_FIRST_RST;
			cfg_q.header_second <= HEADER_SECOND_RST;
			cfg_q.max_payload   <= MAX_PAYLOAD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER_FIRST:  cfg_q.header_first  <= cfg_data;
				CFG_HEADER_SECOND: cfg_q.header_second <= cfg_data;
				CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data[3:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// The held byte is parsed when the output register is free or draining.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign rx_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	ffr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.byte_in   (byte_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid     = valid_s2;
	assign out_kind      = res_s2.out_kind;
	assign payload_byte  = res_s2.payload_byte;
	assign byte_position = res_s2.byte_position;
	assign command       = res_s2.command;
	assign frame_length  = res_s2.frame_length;
	assign verdict       = res_s2.verdict;

endmodule
